// ----- hdl/mrrf_pkg.sv -----
package mrrf_pkg;

    localparam int FRAME_LEN     = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // request kinds
    localparam logic [1:0] REQ_READ_ONE = 2'd0;
    localparam logic [1:0] REQ_READ_TWO = 2'd1;
    localparam logic [1:0] REQ_WRITE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR     = 2'd0;
    localparam logic [1:0] CFG_READ_FUNCTION  = 2'd1;
    localparam logic [1:0] CFG_WRITE_FUNCTION = 2'd2;

    localparam logic [7:0] RST_SLAVE_ADDR     = 8'd1;
    localparam logic [7:0] RST_READ_FUNCTION  = 8'd3;
    localparam logic [7:0] RST_WRITE_FUNCTION = 8'd6;

    // frame positions
    localparam logic [2:0] POS_ADDR     = 3'd0;
    localparam logic [2:0] POS_FUNC     = 3'd1;
    localparam logic [2:0] POS_REG_HI   = 3'd2;
    localparam logic [2:0] POS_REG_LO   = 3'd3;
    localparam logic [2:0] POS_DATA_HI  = 3'd4;
    localparam logic [2:0] POS_DATA_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    // six header bytes of one frame, CRC still to come
    typedef struct packed {
        logic [7:0]  slave_addr;
        logic [7:0]  func;
        logic [15:0] reg_addr;
        logic [15:0] payload;
    } frame_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

// ----- hdl/mrrf_front.sv -----
module mrrf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output mrrf_pkg::frame_t     push_frame
);

    logic [7:0] slave_addr_reg;
    logic [7:0] read_function_reg;
    logic [7:0] write_function_reg;

    logic [15:0] reg_addr;
    logic [15:0] write_value;
    logic        is_frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg     <= mrrf_pkg::RST_SLAVE_ADDR;
            read_function_reg  <= mrrf_pkg::RST_READ_FUNCTION;
            write_function_reg <= mrrf_pkg::RST_WRITE_FUNCTION;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mrrf_pkg::CFG_SLAVE_ADDR:     slave_addr_reg     <= cfg_data;
                mrrf_pkg::CFG_READ_FUNCTION:  read_function_reg  <= cfg_data;
                mrrf_pkg::CFG_WRITE_FUNCTION: write_function_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign reg_addr    = s_tdata[15:0];
    assign write_value = s_tdata[31:16];

    // classify the request and build the header
    always_comb
    begin
        is_frame                = 1'b1;
        push_frame.slave_addr   = slave_addr_reg;
        push_frame.reg_addr     = reg_addr;
        push_frame.func         = read_function_reg;
        push_frame.payload      = 16'd1;
        case (s_tuser)
            mrrf_pkg::REQ_READ_ONE:
                push_frame.payload = 16'd1;
            mrrf_pkg::REQ_READ_TWO:
                push_frame.payload = 16'd2;
            mrrf_pkg::REQ_WRITE:
            begin
                push_frame.func    = write_function_reg;
                push_frame.payload = write_value;
            end
            default:
                is_frame = 1'b0;    // drop unused kind
        endcase
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid & is_frame;

endmodule

// ----- hdl/mrrf_queue.sv -----
module mrrf_queue #(
    parameter int DEPTH = mrrf_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mrrf_pkg::frame_t in_frame,
    output logic             out_valid,
    input  logic             out_ready,
    output mrrf_pkg::frame_t out_frame
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    mrrf_pkg::frame_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_frame = slot_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_frame;
    end

endmodule

// ----- hdl/mrrf_back.sv -----
module mrrf_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mrrf_pkg::frame_t pop_frame,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast
);

    mrrf_pkg::frame_t frame_reg, frame_next;
    logic        busy_reg,  busy_next;
    logic [2:0]  pos_reg,   pos_next;
    logic [15:0] crc_reg,   crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg,  byte_next;
    logic [2:0]  opos_reg,  opos_next;
    logic        last_reg,  last_next;

    logic        load_ok;
    logic [7:0]  cur_byte;

    assign load_ok = !valid_reg || m_tready;

    always_comb
    begin
        case (pos_reg)
            mrrf_pkg::POS_ADDR:    cur_byte = frame_reg.slave_addr;
            mrrf_pkg::POS_FUNC:    cur_byte = frame_reg.func;
            mrrf_pkg::POS_REG_HI:  cur_byte = frame_reg.reg_addr[15:8];
            mrrf_pkg::POS_REG_LO:  cur_byte = frame_reg.reg_addr[7:0];
            mrrf_pkg::POS_DATA_HI: cur_byte = frame_reg.payload[15:8];
            mrrf_pkg::POS_DATA_LO: cur_byte = frame_reg.payload[7:0];
            mrrf_pkg::POS_CRC_LO:  cur_byte = crc_reg[7:0];
            mrrf_pkg::POS_CRC_HI:  cur_byte = crc_reg[15:8];
            default:               cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        frame_next = frame_reg;
        busy_next  = busy_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        opos_next  = opos_reg;
        last_next  = last_reg;
        pop_ready  = 1'b0;

        if (load_ok)
        begin
            valid_next = 1'b0;
            if (busy_reg)
            begin
                valid_next = 1'b1;
                byte_next  = cur_byte;
                opos_next  = pos_reg;
                last_next  = (pos_reg == mrrf_pkg::POS_CRC_HI);
                pos_next   = pos_reg + 3'd1;
                // fold header bytes into the checksum as they leave
                if (pos_reg < mrrf_pkg::POS_CRC_LO)
                    crc_next = mrrf_pkg::crc_byte(crc_reg, cur_byte);
                if (pos_reg == mrrf_pkg::POS_CRC_HI)
                    busy_next = 1'b0;
            end
            else if (pop_valid)
            begin
                // take the next frame and send its first byte at once
                pop_ready  = 1'b1;
                frame_next = pop_frame;
                busy_next  = 1'b1;
                valid_next = 1'b1;
                byte_next  = pop_frame.slave_addr;
                opos_next  = mrrf_pkg::POS_ADDR;
                last_next  = 1'b0;
                pos_next   = mrrf_pkg::POS_FUNC;
                crc_next   = mrrf_pkg::crc_byte(mrrf_pkg::CRC_INIT,
                                                pop_frame.slave_addr);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pos_reg   <= mrrf_pkg::POS_ADDR;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
        crc_reg   <= crc_next;
        byte_reg  <= byte_next;
        opos_reg  <= opos_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, opos_reg, byte_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/modbus_rtu_request_framer.sv -----
// Timing: each request is written into the queue, and the queue feeds the output
// byte register; m_tvalid then rises for the first frame byte. After that, one byte
// per cycle while m_tready is high, eight bytes per request from the one-byte-wide
// output serializer. Requests of the unused kind are taken and yield nothing.
// Reset (rst_n, asynchronous, active low) empties the queue and output stage
// and loads slave_addr 1, read_function 3, write_function 6.
module modbus_rtu_request_framer #(
    parameter int QUEUE_DEPTH = mrrf_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // reg_addr[15:0], write_value[31:16]
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // tx_byte[7:0], byte_pos[10:8], zero[15:11]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic             push_valid, push_ready;
    mrrf_pkg::frame_t push_frame;
    logic             pop_valid,  pop_ready;
    mrrf_pkg::frame_t pop_frame;

    mrrf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    mrrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_frame  (push_frame),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_frame (pop_frame)
    );

    mrrf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_frame (pop_frame),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- test/mrrf_frame_checker.sv -----
module mrrf_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // reg_addr[15:0], write_value[31:16]
    input  logic [1:0]  s_tuser,    // req_type[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // tx_byte[7:0], byte_pos[10:8], zero[15:11]
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatches,
    output int          bytes_due
);

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [2:0] byte_pos;
        logic       frame_end;
    } frame_byte_t;

    frame_byte_t due_bytes[$];

    logic [7:0] slave_addr_q;
    logic [7:0] read_func_q;
    logic [7:0] write_func_q;

    // Build the eight bytes of one request frame and queue them in send order.
    function automatic void queue_frame(input logic [1:0]  kind,
                                        input logic [15:0] addr,
                                        input logic [15:0] wval);
        logic [7:0]  frame_bytes [mrrf_pkg::FRAME_LEN];
        logic [7:0]  func;
        logic [15:0] payload;
        logic [15:0] crc;
        frame_byte_t fb;
        case (kind)
            mrrf_pkg::REQ_READ_ONE:
            begin
                func    = read_func_q;
                payload = 16'd1;
            end
            mrrf_pkg::REQ_READ_TWO:
            begin
                func    = read_func_q;
                payload = 16'd2;
            end
            mrrf_pkg::REQ_WRITE:
            begin
                func    = write_func_q;
                payload = wval;
            end
            default:
                return;
        endcase
        frame_bytes[mrrf_pkg::POS_ADDR]    = slave_addr_q;
        frame_bytes[mrrf_pkg::POS_FUNC]    = func;
        frame_bytes[mrrf_pkg::POS_REG_HI]  = addr[15:8];
        frame_bytes[mrrf_pkg::POS_REG_LO]  = addr[7:0];
        frame_bytes[mrrf_pkg::POS_DATA_HI] = payload[15:8];
        frame_bytes[mrrf_pkg::POS_DATA_LO] = payload[7:0];
        // reflected CRC over the six header bytes, lsb shifted out first
        crc = mrrf_pkg::CRC_INIT;
        for (int i = 0; i < 6; i++)
        begin
            crc[7:0] = crc[7:0] ^ frame_bytes[i];
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ mrrf_pkg::CRC_POLY) : (crc >> 1);
        end
        frame_bytes[mrrf_pkg::POS_CRC_LO] = crc[7:0];
        frame_bytes[mrrf_pkg::POS_CRC_HI] = crc[15:8];
        for (int k = 0; k < mrrf_pkg::FRAME_LEN; k++)
        begin
            fb.tx_byte   = frame_bytes[k];
            fb.byte_pos  = 3'(k);
            fb.frame_end = (k == mrrf_pkg::FRAME_LEN - 1);
            due_bytes.push_back(fb);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_byte_t want;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            due_bytes.delete();
            slave_addr_q <= mrrf_pkg::RST_SLAVE_ADDR;
            read_func_q  <= mrrf_pkg::RST_READ_FUNCTION;
            write_func_q <= mrrf_pkg::RST_WRITE_FUNCTION;
            mismatches   <= 0;
            bytes_due    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mrrf_pkg::CFG_SLAVE_ADDR:     slave_addr_q <= cfg_data;
                    mrrf_pkg::CFG_READ_FUNCTION:  read_func_q  <= cfg_data;
                    mrrf_pkg::CFG_WRITE_FUNCTION: write_func_q <= cfg_data;
                    default:                      ;
                endcase
            end
            if (s_tvalid && s_tready)
                queue_frame(s_tuser, s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready)
            begin
                if (due_bytes.size() == 0)
                begin
                    $error("unexpected frame byte %02h at position %0d",
                           m_tdata[7:0], m_tdata[10:8]);
                    errs++;
                end
                else
                begin
                    want = due_bytes.pop_front();
                    if (m_tdata[7:0] !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %02h, got %02h",
                               want.tx_byte, m_tdata[7:0]);
                        errs++;
                    end
                    if (m_tdata[10:8] !== want.byte_pos)
                    begin
                        $error("byte_pos: expected %0d, got %0d",
                               want.byte_pos, m_tdata[10:8]);
                        errs++;
                    end
                    if (m_tlast !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b",
                               want.frame_end, m_tlast);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
            bytes_due  <= due_bytes.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 16;
    localparam int HOLD_LEN     = 80;
    localparam int RANDOM_REQS  = 280;
    localparam int PHASES       = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // reg_addr[15:0], write_value[31:16]
    logic [1:0]  s_tuser;    // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // tx_byte[7:0], byte_pos[10:8], zero[15:11]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    int mismatches;
    int bytes_due;
    int cycles = 0;

    bit src_gaps    = 1'b1;
    bit sink_gaps   = 1'b1;
    bit hold_asked  = 1'b0;
    bit hold_done   = 1'b0;

    modbus_rtu_request_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mrrf_frame_checker frame_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .bytes_due  (bytes_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[modbus_rtu_request_framer] ERROR");
            $finish;
        end
    end

    // frame byte sink: random stalls, plus one long hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked && !hold_done)
            begin
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    // Call at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high.
    task automatic send_request(input logic [1:0]  kind,
                                input logic [15:0] addr,
                                input logic [15:0] wval);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = {wval, addr};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // drop the request stream and wait until every frame byte has gone out
    task automatic settle();
        s_tvalid = 1'b0;
        while (bytes_due != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [7:0] addr_v,
                             input logic [7:0] rd_v,
                             input logic [7:0] wr_v);
        write_reg(mrrf_pkg::CFG_SLAVE_ADDR, addr_v);
        write_reg(mrrf_pkg::CFG_READ_FUNCTION, rd_v);
        write_reg(mrrf_pkg::CFG_WRITE_FUNCTION, wr_v);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [1:0] kind;
        int         sent;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset register values, field extremes, every request kind
        send_request(mrrf_pkg::REQ_READ_ONE, 16'h0000, 16'h0000);
        send_request(mrrf_pkg::REQ_READ_TWO, 16'hFFFF, 16'hFFFF);
        send_request(mrrf_pkg::REQ_WRITE, 16'h0000, 16'hFFFF);
        send_request(mrrf_pkg::REQ_WRITE, 16'hFFFF, 16'h0000);
        send_request(REQ_UNUSED, 16'h5A5A, 16'hA5A5);
        send_request(mrrf_pkg::REQ_READ_ONE, 16'hA5A5, 16'h5A5A);
        send_request(mrrf_pkg::REQ_WRITE, 16'h1234, 16'hABCD);
        settle();

        write_all(8'h00, 8'h00, 8'h00);
        send_request(mrrf_pkg::REQ_READ_ONE, 16'hFFFF, 16'hFFFF);
        send_request(mrrf_pkg::REQ_READ_TWO, 16'h0000, 16'h0000);
        send_request(mrrf_pkg::REQ_WRITE, 16'h8001, 16'h7FFE);
        settle();

        write_all(8'hFF, 8'hFF, 8'hFF);
        send_request(mrrf_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF);
        send_request(mrrf_pkg::REQ_READ_TWO, 16'h0000, 16'hFFFF);
        send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(mrrf_pkg::REQ_READ_ONE, 16'h00FF, 16'h0000);
        settle();

        // a write to the spare index must leave the registers alone
        write_reg(CFG_SPARE, 8'h5A);
        send_request(mrrf_pkg::REQ_READ_ONE, 16'h0100, 16'h0000);
        send_request(mrrf_pkg::REQ_WRITE, 16'h0001, 16'h00FF);
        send_request(mrrf_pkg::REQ_READ_TWO, 16'hFF00, 16'h1234);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == PHASES - 1)
            begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
            end
            write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            if (phase == 2)
                hold_asked = 1'b1;
            sent = 0;
            while (sent < RANDOM_REQS / PHASES)
            begin
                if (phase == 1 && sent == RANDOM_REQS / (2 * PHASES))
                    settle();
                if ($urandom_range(0, 9) == 0)
                    kind = REQ_UNUSED;
                else
                    kind = 2'($urandom_range(0, 2));
                send_request(kind, pick_word(), pick_word());
                if (kind != REQ_UNUSED)
                    sent++;
            end
        end

        s_tvalid = 1'b0;
        while (bytes_due != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        if (mismatches == 0)
            $display("[modbus_rtu_request_framer] OK");
        else
            $display("[modbus_rtu_request_framer] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mrrf_pkg.sv
hdl/mrrf_front.sv
hdl/mrrf_queue.sv
hdl/mrrf_back.sv
hdl/modbus_rtu_request_framer.sv
test/mrrf_frame_checker.sv
test/tb_top.sv
